### design/aalb_pkg.sv
// shared constants, types and codes for the audio level to brightness block
package aalb_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int WINDOW_DEPTH = 50;
  localparam int GROUP_LENGTH = 10;

  localparam int FACTOR_W  = 12;
  localparam int FRAC_BITS = 10;
  localparam int BRIGHT_W  = 8;

  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int GSUM_W     = $clog2(GROUP_LENGTH * SAMPLE_MAX + 1);
  localparam int GCNT_W     = $clog2(GROUP_LENGTH + 1);
  localparam int TOTAL_W    = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
  localparam int POS_W      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  // products of ring total and a factor; volume*depth*1024 also fits here
  localparam int PROD_W    = TOTAL_W + FACTOR_W;
  localparam int DIFF_W    = PROD_W + 1;
  localparam int DIV_W     = PROD_W + BRIGHT_W;
  localparam int MAP_STEPS = BRIGHT_W + 1;
  localparam int QUO_W     = (MAP_STEPS > SAMPLE_BITS) ? MAP_STEPS : SAMPLE_BITS;
  localparam int STEP_W    = $clog2(QUO_W + 1);

  localparam int CFG_W     = FACTOR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [FACTOR_W-1:0] VALLEY_RESET = 12'd717;
  localparam logic [FACTOR_W-1:0] PEAK_RESET   = 12'd1946;
  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = '1;
  localparam logic [BRIGHT_W-1:0] BRIGHT_ZERO  = '0;

  // group divisor lined up with the top quotient bit of the average
  localparam logic [DIV_W-1:0] AVG_DIVISOR = DIV_W'(GROUP_LENGTH) << (SAMPLE_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALLEY = 1'b0,
    REG_PEAK   = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIFF,
    ST_SCALE,
    ST_DIV_MAP,
    ST_FINISH,
    ST_PUSH,
    ST_DIV_AVG,
    ST_RING
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/aalb_if.sv
// valid/ready channel interfaces for microphone samples and brightness results
interface aalb_in_if import aalb_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   period_end;

  modport source (output valid, sample, period_end, input ready);
  modport sink (input valid, sample, period_end, output ready);
endinterface

interface aalb_out_if import aalb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BRIGHT_W-1:0] brightness;
  logic                calibrating;

  modport source (output valid, brightness, calibrating, input ready);
  modport sink (input valid, brightness, calibrating, output ready);
endinterface

### design/aalb_div.sv
// shared restoring shift-subtract divider, one quotient bit per cycle
module aalb_div import aalb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic              ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // divisor arrives pre-aligned to the top quotient bit and walks right
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsh <= req.divisor;
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider restarted while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start && (req.steps != '0) |=> busy)
    else $error("divider did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

endmodule

### design/adaptive_audio_level_to_brightness_top.sv
// Audio level to LED brightness: each period's peak-to-peak volume, averaged in groups into a
// 50-entry ring, sets a moving reference; volume*50 is mapped between ring_total*valley/1024
// and ring_total*peak/1024 onto 0..255. A sample that does not end a period only updates the
// period minimum and maximum. A sample with period_end produces one result; during warm-up it
// is the full calibrating level, after warm-up the mapping takes three passes through the one
// 16x12 multiplier, then 9 steps of the shared shift-subtract divider (skipped when the result
// clamps to zero) before the result is registered. Every GROUP_LENGTH-th period then adds the
// group average: 10 more divider steps and a ring memory update. A result waits to enter the
// output register while the receiver still holds an earlier one there, which stretches this.
// The input is not ready while this runs; a finished result waits in the output register while
// the next samples are taken. Factor writes are taken on any cycle of the write port and belong
// where no period end is in flight.
module adaptive_audio_level_to_brightness_top import aalb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  aalb_in_if.sink              samples,
  aalb_out_if.source           levels,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  seq_state_t state, state_next;

  logic [FACTOR_W-1:0]    valley;
  logic [FACTOR_W-1:0]    peak;
  logic [SAMPLE_BITS-1:0] min_seen;
  logic [SAMPLE_BITS-1:0] max_seen;
  logic [SAMPLE_BITS-1:0] vol;
  logic [GSUM_W-1:0]      group_sum;
  logic [GCNT_W-1:0]      group_count;
  logic [TOTAL_W-1:0]     ring_total;
  logic [POS_W-1:0]       ring_position;
  logic                   warmed_up;
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;

  logic [TOTAL_W-1:0]       mul_a;
  logic [FACTOR_W-1:0]      mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [PROD_W-1:0]        xval;
  logic [PROD_W-1:0]        lo_prod;
  logic [PROD_W-1:0]        hi_prod;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] den;

  logic [DIFF_W-1:0]      diff_abs;
  logic [DIFF_W-1:0]      den_abs;
  logic [DIV_W-1:0]       num_mag;
  logic [DIV_W-1:0]       den_al;
  logic                   map_zero;

  logic [SAMPLE_BITS-1:0] s_max;
  logic [SAMPLE_BITS-1:0] s_min;
  logic [GSUM_W-1:0]      gsum_next;
  logic                   group_full;
  logic [SAMPLE_BITS-1:0] avg;

  logic [BRIGHT_W-1:0]    res_bright;
  logic                   res_cal;
  logic                   out_valid;
  logic [BRIGHT_W-1:0]    out_bright;
  logic                   out_cal;
  logic                   load_out;
  logic                   accept;

  div_req_t div_req;
  div_rsp_t div_rsp;

  aalb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;

  assign s_max = (samples.sample > max_seen) ? samples.sample : max_seen;
  assign s_min = (samples.sample < min_seen) ? samples.sample : min_seen;

  assign gsum_next  = group_sum + GSUM_W'(vol);
  assign group_full = (group_count == GCNT_W'(GROUP_LENGTH - 1));
  assign avg        = div_rsp.quotient[SAMPLE_BITS-1:0];

  // shared multiplier
  always_comb begin
    case (state)
      ST_MUL_X: begin
        mul_a = TOTAL_W'(vol);
        mul_b = FACTOR_W'(WINDOW_DEPTH);
      end
      ST_MUL_LO: begin
        mul_a = ring_total;
        mul_b = valley;
      end
      default: begin
        mul_a = ring_total;
        mul_b = peak;
      end
    endcase
  end

  assign mul_p = {{FACTOR_W{1'b0}}, mul_a} * {{TOTAL_W{1'b0}}, mul_b};

  // quotient of opposite signs truncates to zero or below, so clamps to zero
  assign map_zero = (den == '0) || (diff == '0) || (diff[DIFF_W-1] != den[DIFF_W-1]);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
  assign den_abs  = den[DIFF_W-1] ? DIFF_W'(-den) : den;
  assign num_mag  = (DIV_W'(diff_abs[PROD_W-1:0]) << BRIGHT_W) - DIV_W'(diff_abs[PROD_W-1:0]);
  assign den_al   = DIV_W'(den_abs[PROD_W-1:0]) << (MAP_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && samples.period_end) begin
          state_next = warmed_up ? ST_MUL_X : ST_FINISH;
        end
      end
      ST_MUL_X:  state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_DIFF;
      ST_DIFF:   state_next = ST_SCALE;
      ST_SCALE: begin
        if (map_zero) begin
          state_next = ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(MAP_STEPS);
          div_req.dividend = num_mag;
          div_req.divisor  = den_al;
          state_next       = ST_DIV_MAP;
        end
      end
      ST_DIV_MAP: begin
        if (div_rsp.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || levels.ready) begin
          load_out   = 1'b1;
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (group_full) begin
          div_req.start    = 1'b1;
          div_req.steps    = STEP_W'(SAMPLE_BITS);
          div_req.dividend = DIV_W'(gsum_next);
          div_req.divisor  = AVG_DIVISOR;
          state_next       = ST_DIV_AVG;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_AVG: begin
        if (div_rsp.done) begin
          state_next = ST_RING;
        end
      end
      ST_RING:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      valley <= VALLEY_RESET;
      peak   <= PEAK_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VALLEY: valley <= cfg_data;
        REG_PEAK:   peak   <= cfg_data;
        default: ;
      endcase
    end
  end

  // period tracking, group and ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      min_seen      <= SAMPLE_BITS'(SAMPLE_MAX);
      max_seen      <= '0;
      group_sum     <= '0;
      group_count   <= '0;
      ring_total    <= '0;
      ring_position <= '0;
      warmed_up     <= 1'b0;
    end else begin
      if (accept) begin
        if (samples.period_end) begin
          min_seen <= SAMPLE_BITS'(SAMPLE_MAX);
          max_seen <= '0;
        end else begin
          min_seen <= s_min;
          max_seen <= s_max;
        end
      end
      if (state == ST_PUSH) begin
        if (group_full) begin
          group_sum   <= '0;
          group_count <= '0;
        end else begin
          group_sum   <= gsum_next;
          group_count <= group_count + GCNT_W'(1);
        end
      end
      if (state == ST_RING) begin
        ring_total <= ring_total - (warmed_up ? TOTAL_W'(rd_data) : TOTAL_W'(0))
                      + TOTAL_W'(avg);
        if (ring_position == POS_W'(WINDOW_DEPTH - 1)) begin
          ring_position <= '0;
          warmed_up     <= 1'b1;
        end else begin
          ring_position <= ring_position + POS_W'(1);
        end
      end
    end
  end

  // ring memory, read data registered; position is stable long before the update
  always_ff @(posedge clk) begin
    rd_data <= ring_mem[ring_position];
    if (state == ST_RING) begin
      ring_mem[ring_position] <= avg;
    end
  end

  // mapping datapath
  always_ff @(posedge clk) begin
    if (accept && samples.period_end) begin
      vol <= s_max - s_min;
    end
    case (state)
      ST_MUL_X:  xval    <= mul_p << FRAC_BITS;
      ST_MUL_LO: lo_prod <= mul_p;
      ST_MUL_HI: hi_prod <= mul_p;
      ST_DIFF: begin
        diff <= $signed({1'b0, xval}) - $signed({1'b0, lo_prod});
        den  <= $signed({1'b0, hi_prod}) - $signed({1'b0, lo_prod});
      end
      default: ;
    endcase
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept && samples.period_end && !warmed_up) begin
      res_bright <= BRIGHT_FULL;
      res_cal    <= 1'b1;
    end else if (state == ST_SCALE && map_zero) begin
      res_bright <= BRIGHT_ZERO;
      res_cal    <= 1'b0;
    end else if (state == ST_DIV_MAP && div_rsp.done) begin
      res_bright <= div_rsp.quotient[MAP_STEPS-1] ? BRIGHT_FULL
                                                   : div_rsp.quotient[BRIGHT_W-1:0];
      res_cal    <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bright <= res_bright;
      out_cal    <= res_cal;
    end
  end

  assign levels.valid       = out_valid;
  assign levels.brightness  = out_bright;
  assign levels.calibrating = out_cal;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ring_position <= POS_W'(WINDOW_DEPTH - 1))
    else $error("ring position out of range");
  a_group_range: assert property (@(posedge clk) disable iff (rst)
    group_count <= GCNT_W'(GROUP_LENGTH - 1))
    else $error("group count out of range");
  a_cal_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_cal |-> out_bright == BRIGHT_FULL)
    else $error("calibrating transaction without full brightness");
  a_ring_idle_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_RING |-> !div_rsp.busy)
    else $error("ring update while divider still running");

endmodule
